// File: rtl/core/wcrc_pkg.sv
// Shared constants and the parallel XOR-network masks for the word CRC block.
// The masks are built at elaboration from the bit-serial update rule.
// No dependencies.
package wcrc_pkg;

    localparam int unsigned WordWidth = 32;

    localparam logic [WordWidth-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [WordWidth-1:0] CRC_POLY = 32'h04C1_1DB7;

    // One row per result bit, one column per source bit
    typedef logic [WordWidth-1:0][WordWidth-1:0] mask_mat_t;

    // Bit-serial update over one word, MSB first. The polynomial goes in once
    // for the bit shifted out and once more for a set data bit.
    // Only used as a constant function to build the masks below.
    function automatic logic [WordWidth-1:0] crc_serial(
        input logic [WordWidth-1:0] acc_in,
        input logic [WordWidth-1:0] word
    );
        logic [WordWidth-1:0] acc;
        logic                 top;
        acc = acc_in;
        for (int i = WordWidth - 1; i >= 0; i--) begin
            top = acc[WordWidth-1];
            acc = {acc[WordWidth-2:0], 1'b0};
            if (top) begin
                acc = acc ^ CRC_POLY;
            end
            if (word[i]) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    // The update is linear over GF(2) in (state, word) with no constant term,
    // so each result bit is a parity over fixed subsets of both inputs.
    function automatic mask_mat_t gen_state_masks();
        mask_mat_t            m;
        logic [WordWidth-1:0] unit;
        logic [WordWidth-1:0] col;
        m = '0;
        for (int k = 0; k < WordWidth; k++) begin
            unit    = '0;
            unit[k] = 1'b1;
            col     = crc_serial(unit, '0);
            for (int j = 0; j < WordWidth; j++) begin
                m[j][k] = col[j];
            end
        end
        return m;
    endfunction

    function automatic mask_mat_t gen_data_masks();
        mask_mat_t            m;
        logic [WordWidth-1:0] unit;
        logic [WordWidth-1:0] col;
        m = '0;
        for (int k = 0; k < WordWidth; k++) begin
            unit    = '0;
            unit[k] = 1'b1;
            col     = crc_serial('0, unit);
            for (int j = 0; j < WordWidth; j++) begin
                m[j][k] = col[j];
            end
        end
        return m;
    endfunction

    localparam mask_mat_t STATE_MASK = gen_state_masks();
    localparam mask_mat_t DATA_MASK  = gen_data_masks();

endpackage

// File: rtl/core/word_crc32_nonstandard.sv
// Top level of the word CRC block: input register, running CRC, result register.
// Depends on wcrc_pkg and wcrc_xor_net.
//
// Usage:
//   Input channel s_*: one 32-bit message word per transaction, s_last_word
//   flags the final word of a message. Result channel m_*: one CRC per
//   message, produced from the transaction that carried s_last_word.
//   Throughput: one word per clock, unless a last word waits on a held
//   result. Each word is absorbed by a flat parity network, so the running
//   CRC register closes its loop every cycle.
//   Result path: an accepted last word waits in the input register, is
//   absorbed, and its CRC is loaded into the result register, which
//   raises m_valid; a stall on m_ready can hold the word back first.
//   Reset (aresetn low, synchronous): both stages empty, running CRC loaded
//   with all ones, m_valid low.
//   Stall: while m_ready is low and a result is held, non-last words keep
//   flowing; a last word waits in the input register, and s_ready drops
//   only once that register is full and blocked.
//   After each message the running CRC reloads all ones.
module word_crc32_nonstandard
    import wcrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WordWidth-1:0] s_data_word,
    input  logic                 s_last_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WordWidth-1:0] m_crc_value
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [WordWidth-1:0] in_data_reg;
    logic                 in_last_reg;
    logic [WordWidth-1:0] crc_reg;
    logic [WordWidth-1:0] crc_next;
    logic [WordWidth-1:0] crc_upd;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WordWidth-1:0] out_crc_reg;
    logic                 out_free;
    logic                 proc_fire;
    logic                 s_fire;

    // Handshake and stage advance
    assign out_free  = !out_valid_reg || m_ready;
    assign proc_fire = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign s_fire    = s_valid && s_ready;

    // Word absorb
    wcrc_xor_net u_xor_net (
        .crc_in    (crc_reg),
        .data_word (in_data_reg),
        .crc_out   (crc_upd)
    );

    // Next-state logic
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end

        crc_next = crc_reg;
        if (proc_fire) begin
            crc_next = in_last_reg ? CRC_INIT : crc_upd;
        end

        out_valid_next = out_valid_reg;
        if (proc_fire && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control and CRC state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_data_word;
            in_last_reg <= s_last_word;
        end
        if (proc_fire && in_last_reg) begin
            out_crc_reg <= crc_upd;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_crc_value = out_crc_reg;

    // Checks
    a_reset_init: assert property (@(posedge aclk)
        !aresetn |=> (crc_reg == CRC_INIT))
        else $error("running CRC not at init after reset");

    a_reload_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && in_last_reg) |=> (crc_reg == CRC_INIT))
        else $error("running CRC not reloaded after last word");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && in_last_reg) |=> (m_valid && (m_crc_value == $past(crc_upd))))
        else $error("result register not loaded from last word");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && in_last_reg) |-> (!out_valid_reg || m_ready))
        else $error("pending result overwritten");

endmodule

// File: rtl/core/wcrc_xor_net.sv
// Parallel CRC update: absorbs one 32-bit word into the running value.
// Depends on wcrc_pkg for the elaboration-time XOR masks.
module wcrc_xor_net
    import wcrc_pkg::*;
(
    input  logic [WordWidth-1:0] crc_in,
    input  logic [WordWidth-1:0] data_word,
    output logic [WordWidth-1:0] crc_out
);

    // Each result bit is an independent parity tree
    always_comb begin
        for (int j = 0; j < WordWidth; j++) begin
            crc_out[j] = (^(crc_in & STATE_MASK[j])) ^ (^(data_word & DATA_MASK[j]));
        end
    end

endmodule

// File: dv/tb_word_crc32_nonstandard.sv
// Self-checking testbench for word_crc32_nonstandard: directed table, then random messages.
// Predicts message CRCs (bit-serial model or table value), compares on the result channel.
// Depends on wcrc_pkg and the word_crc32_nonstandard RTL.
module tb_word_crc32_nonstandard;
    import wcrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One directed transaction; known marks a result typed in by hand
    typedef struct packed {
        logic [WordWidth-1:0] word;
        logic                 last;
        logic                 known;
        logic [WordWidth-1:0] crc;
    } dir_row_t;

    localparam int NumDirRows = 19;

    // All-ones against an all-ones register cancels to zero, and zero words keep it there
    localparam dir_row_t DirRows [0:NumDirRows-1] = '{
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{32'h0000_0000, 1'b1, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
        '{32'h1234_5678, 1'b0, 1'b0, 32'h0},
        '{32'h9ABC_DEF0, 1'b0, 1'b0, 32'h0},
        '{32'h0F0F_0F0F, 1'b1, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
        '{32'h7FFF_FFFE, 1'b1, 1'b0, 32'h0}
    };

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [WordWidth-1:0] s_data_word = '0;
    logic                 s_last_word = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [WordWidth-1:0] m_crc_value;

    // Side data that travels with the driven word
    logic                 cur_known   = 1'b0;
    logic [WordWidth-1:0] cur_crc     = '0;

    bit                   idle_en     = 1'b0;
    logic                 hold_go     = 1'b0;

    logic [WordWidth-1:0] msg_crc;
    logic [WordWidth-1:0] crc_expected [$];
    int                   mismatch_count = 0;

    word_crc32_nonstandard i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data_word(s_data_word),
        .s_last_word(s_last_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_crc_value(m_crc_value)
    );

    always #5 aclk = ~aclk;

    // MSB-first update; the two polynomial XORs cancel when the
    // shifted-out bit equals the data bit
    function automatic logic [WordWidth-1:0] crc_absorb_word(
        input logic [WordWidth-1:0] acc,
        input logic [WordWidth-1:0] word
    );
        logic [WordWidth-1:0] r;
        r = acc;
        for (int b = WordWidth - 1; b >= 0; b--) begin
            if (r[WordWidth-1] ^ word[b]) begin
                r = (r << 1) ^ CRC_POLY;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    function automatic logic [WordWidth-1:0] rand_word();
        logic [WordWidth-1:0] one_hot;
        one_hot = '0;
        one_hot[$urandom_range(WordWidth - 1)] = 1'b1;
        case ($urandom_range(9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return one_hot;
            end
            3: begin
                return ~one_hot;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Offer one word, with an optional random gap first; returns after acceptance
    task automatic send_word(
        input logic [WordWidth-1:0] word,
        input logic                 last,
        input logic                 known,
        input logic [WordWidth-1:0] crc
    );
        if (idle_en) begin
            while ($urandom_range(99) < 21) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_data_word <= word;
        s_last_word <= last;
        cur_known   <= known;
        cur_crc     <= crc;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic send_messages(input int num_words);
        int sent;
        int len;
        sent = 0;
        while (sent < num_words) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
                send_word(rand_word(), (i == len - 1), 1'b0, '0);
            end
            sent += len;
        end
    endtask

    // Prediction on input transactions, checking on result transactions
    always @(posedge aclk) begin
        logic [WordWidth-1:0] want;
        if (!aresetn) begin
            msg_crc = CRC_INIT;
        end else begin
            if (m_valid && m_ready) begin
                if (crc_expected.size() == 0) begin
                    $display("%0t: unexpected crc: expected none, actual %08h",
                             $time, m_crc_value);
                    mismatch_count++;
                end else begin
                    want = crc_expected.pop_front();
                    if (m_crc_value !== want) begin
                        $display("%0t: crc mismatch: expected %08h, actual %08h",
                                 $time, want, m_crc_value);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                msg_crc = crc_absorb_word(msg_crc, s_data_word);
                if (s_last_word) begin
                    crc_expected.push_back(cur_known ? cur_crc : msg_crc);
                    msg_crc = CRC_INIT;
                end
            end
        end
    end

    // Result-side ready: random backpressure plus one long hold-off
    always @(posedge aclk) begin
        int  hold_left;
        bit  hold_used;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
            hold_used = 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_go && !hold_used) begin
            m_ready   <= 1'b0;
            hold_used = 1'b1;
            hold_left = 300;
        end else begin
            m_ready <= idle_en ? ($urandom_range(99) >= 21) : 1'b1;
        end
    end

    // Stimulus and end of test
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        idle_en = 1'b1;
        for (int i = 0; i < NumDirRows; i++) begin
            send_word(DirRows[i].word, DirRows[i].last, DirRows[i].known, DirRows[i].crc);
        end

        // Back-to-back stretch, no idling on either side
        idle_en = 1'b0;
        send_messages(350);

        // Idling on both sides; the receiver stalls long right away
        idle_en = 1'b1;
        hold_go <= 1'b1;
        send_messages(950);

        s_valid <= 1'b0;
        // Let the predictor record the final accepted word first
        @(posedge aclk);
        while (crc_expected.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/wcrc_pkg.sv
rtl/core/wcrc_xor_net.sv
rtl/core/word_crc32_nonstandard.sv
dv/tb_word_crc32_nonstandard.sv
